[hdl/auaq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// auaq_pkg
// Shared types, codes and sizes for the access-unit admission queue.
// ----------------------------------------------------------------------------
package auaq_pkg;

    localparam int QueueDepth = 64;
    localparam int PtrW       = $clog2(QueueDepth);
    localparam int CntW       = 7;
    localparam int SizeW      = 27;
    localparam int AgeW       = 31;
    // One entry memory word: time, size, handle.
    localparam int EntW       = 64 + SizeW + 32;

    // Operation codes.
    localparam logic [1:0] FUNC_ENQ  = 2'd0;
    localparam logic [1:0] FUNC_DEQ  = 2'd1;
    localparam logic [1:0] FUNC_REC  = 2'd2;
    localparam logic [1:0] FUNC_STOP = 2'd3;

    // Reason codes.
    localparam logic [3:0] R_ACCEPTED  = 4'd0;
    localparam logic [3:0] R_DEQUEUED  = 4'd1;
    localparam logic [3:0] R_UNUSABLE  = 4'd2;
    localparam logic [3:0] R_STOPPED   = 4'd3;
    localparam logic [3:0] R_TIME      = 4'd4;
    localparam logic [3:0] R_INVALID   = 4'd5;
    localparam logic [3:0] R_STALE     = 4'd6;
    localparam logic [3:0] R_AGE       = 4'd7;
    localparam logic [3:0] R_AWAIT     = 4'd8;
    localparam logic [3:0] R_TOO_LARGE = 4'd9;
    localparam logic [3:0] R_CAPACITY  = 4'd10;
    localparam logic [3:0] R_EMPTY     = 4'd11;
    localparam logic [3:0] R_RECOVERY  = 4'd12;
    localparam logic [3:0] R_NOACTION  = 4'd13;
    localparam logic [3:0] R_STOPNOW   = 4'd14;

    // Register indexes.
    localparam logic [1:0] REG_MAX_UNITS = 2'd0;
    localparam logic [1:0] REG_MAX_BYTES = 2'd1;
    localparam logic [1:0] REG_MAX_AGE   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture the input item and read the head entry
        logic exec;   // evaluate and commit the operation
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic done;
    } t_status;

    typedef struct packed {
        logic             accepted;
        logic             recovery_needed;
        logic             unusable;
        logic [3:0]       reason;
        logic [31:0]      out_handle;
        logic [SizeW-1:0] out_size;
        logic [CntW-1:0]  queued_units;
        logic [SizeW-1:0] queued_bytes;
        logic             waiting_recovery;
    } t_result;

endpackage
`default_nettype wire

[hdl/auaq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// auaq_ctrl
// Controller: takes an item, runs it through the datapath, holds the result.
// ----------------------------------------------------------------------------
module auaq_ctrl
    import auaq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[hdl/auaq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// auaq_dp
// Datapath: entry memory, queue state, admission checks and result register.
// ----------------------------------------------------------------------------
module auaq_dp
    import auaq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic [1:0]       i_func,
    input  wire logic [63:0]      i_now_time,
    input  wire logic [31:0]      i_unit_handle,
    input  wire logic [SizeW-1:0] i_unit_size,
    input  wire logic [31:0]      i_unit_media,
    input  wire logic [31:0]      i_dep_epoch,
    input  wire logic [1:0]       i_pic_kind,
    input  wire logic             i_is_keyframe,
    input  wire logic             i_has_param_sets,
    input  wire logic             i_hash_ok,
    input  wire logic             i_meta_ok,
    input  wire logic [CntW-1:0]  i_max_units,
    input  wire logic [SizeW-1:0] i_max_bytes,
    input  wire logic [AgeW-1:0]  i_max_age,
    output t_result               o_result
);

    // Entry memory, one word per slot: time, size, handle.
    logic [EntW-1:0] r_mem [QueueDepth];
    logic [EntW-1:0] r_head_rd;

    // Captured item.
    logic [1:0]       r_func;
    logic [63:0]      r_now;
    logic [31:0]      r_handle;
    logic [SizeW-1:0] r_size;
    logic [31:0]      r_me, r_de;
    logic [1:0]       r_kind;
    logic             r_key, r_ps, r_hash, r_meta;

    // Queue state.
    logic [PtrW-1:0]  r_head, r_tail, n_head, n_tail;
    logic [CntW-1:0]  r_count, n_count;
    logic [SizeW-1:0] r_bytes, n_bytes;
    logic r_open, n_open, r_failed, n_failed, r_await, n_await;
    logic [63:0] r_last, n_last;
    logic r_last_v, n_last_v;
    logic [31:0] r_fm, r_fd, n_fm, n_fd;
    logic r_fv, n_fv;

    t_result         r_res, n_res;
    logic            wr_en;
    logic [PtrW-1:0] wr_slot;

    // Head entry fields.
    logic [63:0]      head_time;
    logic [SizeW-1:0] head_size;
    logic [31:0]      head_handle;
    assign head_time   = r_head_rd[EntW-1 -: 64];
    assign head_size   = r_head_rd[32 +: SizeW];
    assign head_handle = r_head_rd[31:0];

    // Memory write and registered head read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_slot] <= {r_now, r_size, r_handle};
        end
        if (i_cmd.load) begin
            r_head_rd <= r_mem[r_head];
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_now    <= i_now_time;
            r_handle <= i_unit_handle;
            r_size   <= i_unit_size;
            r_me     <= i_unit_media;
            r_de     <= i_dep_epoch;
            r_kind   <= i_pic_kind;
            r_key    <= i_is_keyframe;
            r_ps     <= i_has_param_sets;
            r_hash   <= i_hash_ok;
            r_meta   <= i_meta_ok;
        end
    end

    // Shared checks.
    logic        time_bad, expired, valid, recovery, stale, changed;
    logic [63:0] age;
    logic [CntW-1:0] lim;
    logic [SizeW:0]  sum;
    assign time_bad = r_last_v && (r_now < r_last);
    assign age      = r_now - head_time;
    assign expired  = (r_count != '0) && (age >= {33'd0, i_max_age});
    assign valid    = (r_size != '0) && (r_me != '0) && (r_de != '0) && r_meta &&
                      (r_handle != '0) && r_hash && (r_ps == r_key) &&
                      (r_kind <= 2'd1) && ((r_kind == 2'd0) == r_key);
    assign recovery = r_key && r_ps && (r_kind == 2'd0);
    assign stale    = r_fv && ((r_me < r_fm) || ((r_me == r_fm) && (r_de < r_fd)));
    assign changed  = r_fv && ((r_me > r_fm) || ((r_me == r_fm) && (r_de > r_fd)));
    assign lim      = (i_max_units < CntW'(QueueDepth)) ? i_max_units
                                                       : CntW'(QueueDepth);
    assign sum      = {1'b0, r_bytes} + {1'b0, r_size};

    // Operation evaluation.
    always_comb begin
        logic [3:0]  rsn;
        logic        acc, rec, purge;
        logic [31:0] oh;
        logic [SizeW-1:0] os;
        rsn = R_NOACTION; acc = 1'b0; rec = 1'b0; purge = 1'b0;
        oh = '0; os = '0;
        n_head = r_head; n_tail = r_tail; n_count = r_count; n_bytes = r_bytes;
        n_open = r_open; n_failed = r_failed; n_await = r_await;
        n_last = r_last; n_last_v = r_last_v;
        n_fm = r_fm; n_fd = r_fd; n_fv = r_fv;
        wr_en = 1'b0;
        if (!r_open && r_func != FUNC_STOP) begin
            rec = r_await;
            rsn = r_failed ? R_UNUSABLE : R_STOPPED;
        end else begin
            unique case (r_func)
                FUNC_ENQ, FUNC_DEQ: begin
                    if (time_bad) begin
                        n_open = 1'b0; n_failed = 1'b1; purge = 1'b1;
                        rec = 1'b1; rsn = R_TIME;
                    end else begin
                        n_last = r_now; n_last_v = 1'b1;
                        if (expired) purge = 1'b1;
                        if (r_func == FUNC_DEQ) begin
                            if (expired) begin
                                rec = 1'b1; rsn = R_AGE;
                            end else if (r_count == '0) begin
                                rec = r_await; rsn = R_EMPTY;
                            end else begin
                                oh = head_handle; os = head_size;
                                n_head  = r_head + 1'b1;
                                n_count = r_count - 1'b1;
                                n_bytes = (r_bytes >= head_size) ? r_bytes - head_size
                                                                 : '0;
                                acc = 1'b1; rsn = R_DEQUEUED;
                            end
                        end else if (!valid) begin
                            rec = r_await || expired; rsn = R_INVALID;
                        end else if (stale) begin
                            rec = r_await || expired; rsn = R_STALE;
                        end else begin
                            if (changed) begin
                                purge = 1'b1; n_fm = r_me; n_fd = r_de;
                            end
                            if ((r_await || expired || changed) && !recovery) begin
                                rec = 1'b1; rsn = expired ? R_AGE : R_AWAIT;
                            end else if (r_size > i_max_bytes) begin
                                if (recovery) begin
                                    n_open = 1'b0; n_failed = 1'b1;
                                end
                                purge = 1'b1; rec = 1'b1;
                                rsn = recovery ? R_TOO_LARGE : R_CAPACITY;
                            end else if (!(expired || changed) &&
                                         ((r_count >= lim) ||
                                          (sum > {1'b0, i_max_bytes}))) begin
                                purge = 1'b1; rec = 1'b1; rsn = R_CAPACITY;
                            end else if ((expired || changed) && (lim == '0)) begin
                                purge = 1'b1; rec = 1'b1; rsn = R_CAPACITY;
                            end else begin
                                // Admit; a purge this step leaves the queue empty.
                                n_await = 1'b0; n_fm = r_me; n_fd = r_de;
                                n_fv = 1'b1; wr_en = 1'b1; acc = 1'b1;
                                rsn = R_ACCEPTED;
                            end
                        end
                    end
                end
                FUNC_REC: begin
                    if (!(r_await && r_count == '0)) purge = 1'b1;
                    rec = 1'b1; rsn = R_RECOVERY;
                end
                default: begin
                    if (!r_open) begin
                        rsn = R_NOACTION;
                    end else begin
                        n_open = 1'b0; purge = 1'b1; rsn = R_STOPNOW;
                    end
                end
            endcase
        end
        if (purge) begin
            n_head = '0; n_tail = '0; n_count = '0; n_bytes = '0; n_await = 1'b1;
        end
        // Admission applies after any purge of this step.
        if (wr_en) begin
            n_await = 1'b0;
        end
        // An admitted item goes to the tail slot, which is slot zero after a purge.
        wr_slot = n_tail;
        if (acc && rsn == R_ACCEPTED) begin
            n_tail  = n_tail + 1'b1;
            n_count = n_count + 1'b1;
            n_bytes = n_bytes + r_size;
        end
        if (r_func == FUNC_STOP) rec = n_await;
        n_res.accepted         = acc;
        n_res.recovery_needed  = rec;
        n_res.unusable         = n_failed;
        n_res.reason           = rsn;
        n_res.out_handle       = oh;
        n_res.out_size         = os;
        n_res.queued_units     = n_count;
        n_res.queued_bytes     = n_bytes;
        n_res.waiting_recovery = n_await;
    end

    // State commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_count <= '0; r_bytes <= '0;
            r_open <= 1'b1; r_failed <= 1'b0; r_await <= 1'b1;
            r_last <= '0; r_last_v <= 1'b0;
            r_fm <= '0; r_fd <= '0; r_fv <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head <= n_head; r_tail <= n_tail; r_count <= n_count;
            r_bytes <= n_bytes; r_open <= n_open; r_failed <= n_failed;
            r_await <= n_await; r_last <= n_last; r_last_v <= n_last_v;
            r_fm <= n_fm; r_fd <= n_fd; r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_result      = r_res;
    assign o_status.done = i_cmd.exec;

endmodule
`default_nettype wire

[hdl/access_unit_admission_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// access_unit_admission_queue_unit
// Bounded queue of video access-unit descriptors with admission control.
// ----------------------------------------------------------------------------
// Each input item is one operation and gives one result item. An accepted
// item is captured while the head entry is read from the single-port entry
// memory; in the next cycle the operation is evaluated and committed and its
// result is loaded into the output register, where it is offered from the
// following cycle until taken. The next item is accepted in the cycle after
// the result is taken, so the block works on one item at a time. The entry
// memory needs no clearing after reset.
module access_unit_admission_queue_unit
    import auaq_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: func[1:0], now_time[65:2], unit_handle[97:66], unit_size[124:98],
    // media_ep[156:125], dep_epoch[188:157], pic_kind[190:189],
    // is_keyframe[191], has_param_sets[192], hash_ok[193], meta_ok[194]
    input  wire logic [199:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: accepted[0], recovery_needed[1], unusable[2], reason[6:3],
    // out_handle[38:7], out_size[65:39], queued_units[72:66],
    // queued_bytes[99:73], waiting_recovery[100]
    output logic [103:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CntW-1:0]  r_max_units;
    logic [SizeW-1:0] r_max_bytes;
    logic [AgeW-1:0]  r_max_age;
    logic [1:0]       reg_idx;
    t_cmd    cmd;
    t_status status;
    t_result res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= CntW'(64);
            r_max_bytes <= SizeW'(67108864);
            r_max_age   <= AgeW'(2000000000);
        end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) begin
            unique case (reg_idx)
                REG_MAX_UNITS: r_max_units <= pwdata[CntW-1:0];
                REG_MAX_BYTES: r_max_bytes <= pwdata[SizeW-1:0];
                REG_MAX_AGE:   r_max_age   <= pwdata[AgeW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (reg_idx)
                REG_MAX_UNITS: prdata = 32'(r_max_units);
                REG_MAX_BYTES: prdata = 32'(r_max_bytes);
                REG_MAX_AGE:   prdata = 32'(r_max_age);
                default:       prdata = '0;
            endcase
        end
    end

    auaq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    auaq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_func           (s_axis_tdata[1:0]),
        .i_now_time       (s_axis_tdata[65:2]),
        .i_unit_handle    (s_axis_tdata[97:66]),
        .i_unit_size      (s_axis_tdata[124:98]),
        .i_unit_media     (s_axis_tdata[156:125]),
        .i_dep_epoch      (s_axis_tdata[188:157]),
        .i_pic_kind       (s_axis_tdata[190:189]),
        .i_is_keyframe    (s_axis_tdata[191]),
        .i_has_param_sets (s_axis_tdata[192]),
        .i_hash_ok        (s_axis_tdata[193]),
        .i_meta_ok        (s_axis_tdata[194]),
        .i_max_units      (r_max_units),
        .i_max_bytes      (r_max_bytes),
        .i_max_age        (r_max_age),
        .o_result         (res)
    );

    // Result packing.
    assign m_axis_tdata = {3'b000, res.waiting_recovery, res.queued_bytes,
                           res.queued_units, res.out_size, res.out_handle,
                           res.reason, res.unusable, res.recovery_needed,
                           res.accepted};

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the access-unit admission queue. A behavioral
// queue model predicts every result item from the accepted input items. The
// run walks through several register settings, sender and receiver stall
// mixes, and ends with one of the ways the queue closes for good.
// ----------------------------------------------------------------------------
module tb;
    import auaq_pkg::*;

    localparam int CycleLimit = 600000;
    localparam logic [26:0] MaxBytesTop = 27'd67108864;

    typedef struct {
        logic [1:0]  func;
        logic [63:0] now;
        logic [31:0] handle;
        logic [26:0] size;
        logic [31:0] media;
        logic [31:0] dep;
        logic [1:0]  kind;
        logic        key;
        logic        psets;
        logic        hash;
        logic        meta;
    } t_au_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    access_unit_admission_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Queue model: registers and state.
    logic [6:0]  lim_units;
    logic [26:0] lim_bytes;
    logic [30:0] lim_age;
    logic [31:0] slot_handle [QueueDepth];
    logic [26:0] slot_size [QueueDepth];
    logic [63:0] slot_time [QueueDepth];
    logic [5:0]  rd_ptr;
    logic [5:0]  wr_ptr;
    logic [6:0]  held_units;
    logic [26:0] held_bytes;
    logic        is_open;
    logic        is_failed;
    logic        needs_idr;
    logic [63:0] prev_time;
    logic        prev_time_seen;
    logic [31:0] floor_media;
    logic [31:0] floor_dep;
    logic        floor_set;

    // Stimulus state.
    logic [63:0] clock_ns;
    logic [31:0] cur_media;
    logic [31:0] cur_dep;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          errors;
    int          cycles;
    t_result     pending_results [$];

    function automatic void flush_queue();
        rd_ptr     = '0;
        wr_ptr     = '0;
        held_units = '0;
        held_bytes = '0;
        needs_idr  = 1'b1;
    endfunction

    function automatic logic time_forward(logic [63:0] now);
        if (prev_time_seen && now < prev_time) begin
            is_open   = 1'b0;
            is_failed = 1'b1;
            flush_queue();
            return 1'b0;
        end
        prev_time      = now;
        prev_time_seen = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic head_expired(logic [63:0] now);
        if (held_units == 0) return 1'b0;
        if (now - slot_time[rd_ptr] < {33'd0, lim_age}) return 1'b0;
        flush_queue();
        return 1'b1;
    endfunction

    // Admission of one access unit.
    function automatic void admit_unit(t_au_item it, ref t_result r);
        logic expired, valid, recov, stale, changed;
        logic [6:0] cap;
        if (!time_forward(it.now)) begin
            r.recovery_needed = 1'b1;
            r.reason = R_TIME;
            return;
        end
        expired = head_expired(it.now);
        valid = it.size != 0 && it.media != 0 && it.dep != 0 && it.meta &&
                it.handle != 0 && it.hash && it.psets == it.key && it.kind <= 1 &&
                ((it.kind == 0) == it.key);
        if (!valid) begin
            r.recovery_needed = needs_idr;
            r.reason = R_INVALID;
            return;
        end
        recov = it.key && it.psets && it.kind == 0;
        stale = floor_set && (it.media < floor_media ||
                (it.media == floor_media && it.dep < floor_dep));
        if (stale) begin
            r.recovery_needed = needs_idr;
            r.reason = R_STALE;
            return;
        end
        changed = floor_set && (it.media > floor_media ||
                  (it.media == floor_media && it.dep > floor_dep));
        if (changed) begin
            flush_queue();
            floor_media = it.media;
            floor_dep   = it.dep;
        end
        cap = (lim_units < 7'd64) ? lim_units : 7'd64;
        if (needs_idr && !recov) begin
            r.recovery_needed = 1'b1;
            r.reason = expired ? R_AGE : R_AWAIT;
        end else if (it.size > lim_bytes) begin
            if (recov) begin
                is_open   = 1'b0;
                is_failed = 1'b1;
            end
            flush_queue();
            r.recovery_needed = 1'b1;
            r.reason = recov ? R_TOO_LARGE : R_CAPACITY;
        end else if (held_units >= cap ||
                     {1'b0, held_bytes} + {1'b0, it.size} > {1'b0, lim_bytes}) begin
            flush_queue();
            r.recovery_needed = 1'b1;
            r.reason = R_CAPACITY;
        end else begin
            if (needs_idr) begin
                needs_idr   = 1'b0;
                floor_media = it.media;
                floor_dep   = it.dep;
                floor_set   = 1'b1;
            end
            slot_handle[wr_ptr] = it.handle;
            slot_size[wr_ptr]   = it.size;
            slot_time[wr_ptr]   = it.now;
            wr_ptr     = wr_ptr + 1'b1;
            held_units = held_units + 1'b1;
            held_bytes = held_bytes + it.size;
            r.accepted = 1'b1;
            r.reason   = R_ACCEPTED;
        end
    endfunction

    // Works out the result item of one operation and advances the model.
    function automatic t_result queue_outcome(t_au_item it);
        t_result r;
        r = '0;
        if (!is_open) begin
            r.recovery_needed = needs_idr;
            if (it.func == FUNC_STOP) r.reason = R_NOACTION;
            else r.reason = is_failed ? R_UNUSABLE : R_STOPPED;
        end else begin
            case (it.func)
                FUNC_ENQ: admit_unit(it, r);
                FUNC_DEQ: begin
                    if (!time_forward(it.now)) begin
                        r.recovery_needed = 1'b1;
                        r.reason = R_TIME;
                    end else if (head_expired(it.now)) begin
                        r.recovery_needed = 1'b1;
                        r.reason = R_AGE;
                    end else if (held_units == 0) begin
                        r.recovery_needed = needs_idr;
                        r.reason = R_EMPTY;
                    end else begin
                        r.out_handle = slot_handle[rd_ptr];
                        r.out_size   = slot_size[rd_ptr];
                        held_bytes = (held_bytes >= r.out_size) ?
                                     held_bytes - r.out_size : '0;
                        rd_ptr     = rd_ptr + 1'b1;
                        held_units = held_units - 1'b1;
                        r.accepted = 1'b1;
                        r.reason   = R_DEQUEUED;
                    end
                end
                FUNC_REC: begin
                    if (!(needs_idr && held_units == 0)) flush_queue();
                    r.recovery_needed = 1'b1;
                    r.reason = R_RECOVERY;
                end
                default: begin
                    is_open = 1'b0;
                    flush_queue();
                    r.reason = R_STOPNOW;
                    r.recovery_needed = needs_idr;
                end
            endcase
        end
        r.unusable         = is_failed;
        r.queued_units     = held_units;
        r.queued_bytes     = held_bytes;
        r.waiting_recovery = needs_idr;
        return r;
    endfunction

    // Sends one item, after a random gap, and records its expected result.
    task automatic send_item(t_au_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, it.meta, it.hash, it.psets, it.key, it.kind, it.dep,
                         it.media, it.size, it.handle, it.now, it.func};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.insert(pending_results.size(), queue_outcome(it));
    endtask

    task automatic wait_drained(int settle);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_MAX_UNITS: lim_units = value[6:0];
            REG_MAX_BYTES: lim_bytes = value[26:0];
            default:       lim_age   = value[30:0];
        endcase
    endtask

    task automatic apply_limits(logic [6:0] units, logic [26:0] bytes, logic [30:0] age);
        wait_drained(6);
        write_reg(REG_MAX_UNITS, {25'd0, units});
        write_reg(REG_MAX_BYTES, {5'd0, bytes});
        write_reg(REG_MAX_AGE, {1'b0, age});
    endtask

    // A well-formed unit at the current epochs: an IDR unit when idr is set.
    function automatic t_au_item good_unit(logic idr);
        t_au_item it;
        it.func   = FUNC_ENQ;
        it.now    = clock_ns;
        it.handle = $urandom;
        if (it.handle == 0) it.handle = 32'd1;
        it.size   = 27'($urandom_range(1, 4096));
        it.media  = cur_media;
        it.dep    = cur_dep;
        it.kind   = idr ? 2'd0 : 2'd1;
        it.key    = idr;
        it.psets  = idr;
        it.hash   = 1'b1;
        it.meta   = 1'b1;
        return it;
    endfunction

    function automatic t_au_item take_unit();
        t_au_item it;
        it = good_unit(1'b0);
        it.func   = FUNC_DEQ;
        it.handle = $urandom;
        it.size   = 27'($urandom);
        return it;
    endfunction

    // Directed items: enqueue, dequeue and recovery operations, the field extremes and corner cases.
    task automatic test_directed();
        t_au_item it;
        clock_ns = '0;
        send_item(take_unit());                           // empty queue
        send_item(good_unit(1'b0));                       // predicted while awaiting IDR
        it = good_unit(1'b0); it.handle = '0; send_item(it);
        it = good_unit(1'b0); it.size = '0; send_item(it);
        it = good_unit(1'b0); it.media = '0; send_item(it);
        it = good_unit(1'b0); it.dep = '0; send_item(it);
        it = good_unit(1'b0); it.kind = 2'd2; send_item(it);
        it = good_unit(1'b0); it.kind = 2'd3; send_item(it);
        it = good_unit(1'b0); it.key = 1'b1; send_item(it);   // keyframe flag mismatch
        it = good_unit(1'b0); it.hash = 1'b0; send_item(it);
        it = good_unit(1'b0); it.meta = 1'b0; send_item(it);
        cur_media = 32'd5; cur_dep = 32'd5;
        it = good_unit(1'b1); it.handle = '1; it.size = MaxBytesTop; send_item(it);
        send_item(take_unit());                           // delivers the largest unit
        send_item(good_unit(1'b1));
        send_item(good_unit(1'b0));
        it = good_unit(1'b0); it.size = '1; send_item(it);    // larger than the byte limit
        send_item(good_unit(1'b1));
        it = good_unit(1'b0); it.media = 32'd4; send_item(it); // older media epoch
        it = good_unit(1'b0); it.dep = 32'd4; send_item(it);   // older dependency epoch
        cur_dep = 32'd6;
        send_item(good_unit(1'b0));                       // newer epoch purges
        send_item(good_unit(1'b1));
        clock_ns = clock_ns + lim_age;
        send_item(take_unit());                           // head aged out
        it = good_unit(1'b1); it.func = FUNC_REC; send_item(it);
        send_item(it);                                    // already empty and awaiting
    endtask

    // Random operations, mostly well-formed streams with some broken units.
    task automatic test_random(int count, int pause_at);
        t_au_item it;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) wait_drained(0);
            pick = $urandom_range(99);
            if ($urandom_range(99) < 3) clock_ns = clock_ns + $urandom;
            else clock_ns = clock_ns + $urandom_range(0, 1000);
            if ($urandom_range(99) < 3) begin
                if ($urandom_range(1)) begin
                    if (cur_media < 32'hC000_0000)
                        cur_media = cur_media + $urandom_range(1, 32'h3FFF_FFFF);
                    cur_dep = $urandom | 32'd1;
                end else if (cur_dep != '1) begin
                    cur_dep = cur_dep + 1'b1;
                end
            end
            if (pick < 55) begin
                it = good_unit(needs_idr || $urandom_range(99) < 10);
                if ($urandom_range(99) < 4) it.size = 27'($urandom_range(1, MaxBytesTop));
                if ($urandom_range(99) < 14) begin
                    case ($urandom_range(8))
                        0: it.handle = '0;
                        1: it.size = '0;
                        2: it.media = '0;
                        3: it.dep = '0;
                        4: it.kind = 2'($urandom_range(3));
                        5: begin it.key = 1'($urandom); it.psets = 1'($urandom); end
                        6: begin it.hash = 1'($urandom); it.meta = 1'($urandom); end
                        7: if (cur_media > 1) it.media = cur_media - 1'b1;
                        default: begin
                            it.handle = $urandom;        it.size  = 27'($urandom);
                            it.media  = $urandom;        it.dep   = $urandom;
                            it.kind   = 2'($urandom);    it.key   = 1'($urandom);
                            it.psets  = 1'($urandom);    it.hash  = 1'($urandom);
                            it.meta   = 1'($urandom);
                        end
                    endcase
                end
            end else if (pick < 96) begin
                it = take_unit();
            end else begin
                it = take_unit();
                it.func = FUNC_REC;
            end
            send_item(it);
        end
    endtask

    // Closes the queue for good in one of its three ways, then probes it.
    task automatic test_close();
        t_au_item it;
        apply_limits(7'd64, MaxBytesTop, 31'd2000000000);
        clock_ns = clock_ns + 1;
        case ($urandom_range(2))
            0: begin
                it = take_unit(); it.now = clock_ns - 1; send_item(it);
            end
            1: begin
                it = good_unit(1'b1);
                if (floor_set) begin it.media = floor_media; it.dep = floor_dep; end
                it.size = MaxBytesTop + 1'b1;
                send_item(it);
            end
            default: begin
                it = take_unit(); it.func = FUNC_STOP; send_item(it);
            end
        endcase
        it = take_unit(); it.func = FUNC_STOP; send_item(it);
        send_item(good_unit(1'b1));
        send_item(take_unit());
        it = take_unit(); it.func = FUNC_REC; send_item(it);
        wait_drained(10);
    endtask

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.accepted         = m_axis_tdata[0];
            got.recovery_needed  = m_axis_tdata[1];
            got.unusable         = m_axis_tdata[2];
            got.reason           = m_axis_tdata[6:3];
            got.out_handle       = m_axis_tdata[38:7];
            got.out_size         = m_axis_tdata[65:39];
            got.queued_units     = m_axis_tdata[72:66];
            got.queued_bytes     = m_axis_tdata[99:73];
            got.waiting_recovery = m_axis_tdata[100];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: acc %b/%b rec %b/%b unus %b/%b reason %0d/%0d %s",
                                 want.accepted, got.accepted, want.recovery_needed,
                                 got.recovery_needed, want.unusable, got.unusable,
                                 want.reason, got.reason,
                                 $sformatf("handle %h/%h size %0d/%0d units %0d/%0d %s",
                                     want.out_handle, got.out_handle, want.out_size,
                                     got.out_size, want.queued_units, got.queued_units,
                                     $sformatf("bytes %0d/%0d wait %b/%b (expected/actual)",
                                         want.queued_bytes, got.queued_bytes,
                                         want.waiting_recovery, got.waiting_recovery)));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        lim_units = 7'd64;
        lim_bytes = MaxBytesTop;
        lim_age = 31'd2000000000;
        is_open = 1'b1;
        is_failed = 1'b0;
        prev_time = '0;
        prev_time_seen = 1'b0;
        floor_media = '0;
        floor_dep = '0;
        floor_set = 1'b0;
        cur_media = 32'd1;
        cur_dep = 32'd1;
        flush_queue();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();

        apply_limits(7'd64, MaxBytesTop, 31'd2000000000);
        test_random(230, -1);

        tx_idle_pct = 87;
        clock_ns = 64'h5555_5555_5555_5555;
        apply_limits(7'd1, MaxBytesTop, 31'd2000000000);
        test_random(230, 100);

        tx_idle_pct = 0;
        rx_stall_pct = 87;
        apply_limits(7'd64, 27'd1, 31'd1);
        test_random(230, -1);

        tx_idle_pct = 31;
        rx_stall_pct = 31;
        clock_ns = 64'hAAAA_AAAA_AAAA_AAAA;
        apply_limits(7'd4, 27'd20000, 31'd2000000000);
        test_random(230, -1);

        apply_limits(7'd16, 27'd9000, 31'd50000);
        test_random(230, -1);

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        clock_ns = 64'hFFFF_FFFF_0000_0000;
        apply_limits(7'd64, MaxBytesTop, 31'd2000000000);
        test_random(230, -1);

        test_close();

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
